// ----- rtl/core/aalr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aalr_pkg
// Shared types and constants of the antialiased line rasterizer.
// ----------------------------------------------------------------------------
package aalr_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 16;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int AW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DIM_W  = 9;
  localparam int CRD_W  = 11;
  localparam int PIX_W  = 24;
  localparam int RES_W  = 32;
  localparam int CMD_W  = 2;
  localparam int CIDX_W = 1;

  localparam int DW     = CRD_W + 1;                 // endpoint difference
  localparam int SW     = 2 * DW;                    // squared length
  localparam int VW     = SW + 2 * FRAC_BITS;        // radicand
  localparam int UW     = VW + 2;                    // shared subtractor
  localparam int LW     = VW / 2;                    // fixed-point length
  localparam int NUMW   = DW - 1 + 2 * FRAC_BITS;    // dividend magnitude
  localparam int QW     = FRAC_BITS + 2;             // direction
  localparam int PW     = 32;                        // position
  localparam int IW     = 16;                        // integer pixel coordinate
  localparam int FW     = FRAC_BITS + 2;             // signed fraction
  localparam int AFW    = FRAC_BITS + 3;             // weight factor
  localparam int PRW    = 2 * AFW;                   // weight product
  localparam int WW     = FRAC_BITS + 1;             // weight
  localparam int CW     = LW - FRAC_BITS + 1;        // iteration counter

  localparam int ISQ_ITERS = VW / 2;

  localparam logic signed [AFW-1:0] ONE_F = AFW'(1) <<< FRAC_BITS;
  localparam logic [WW-1:0]         ONE_W = WW'(1) << FRAC_BITS;
  localparam logic [7:0]            ALPHA = 8'hFF;

  localparam logic [CIDX_W-1:0] CFG_WIDTH  = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = CIDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LINE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ISQ,
    ST_DIVX,
    ST_DIVY,
    ST_POS,
    ST_NB,
    ST_PRD,
    ST_PBL,
    ST_NEXT,
    ST_WMUL,
    ST_WWR,
    ST_RMUL,
    ST_RRD,
    ST_ROUT
  } state_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AW-1:0]    addr;
    logic [PIX_W-1:0] wdata;
  } fs_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/aalr_fstore.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aalr_fstore
// Single-port RGB frame store with registered read data.
// ----------------------------------------------------------------------------
module aalr_fstore (
  input  logic                    clk_i,
  input  aalr_pkg::fs_req_t       req_i,
  output logic [aalr_pkg::PIX_W-1:0] rdata_o
);
  import aalr_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/core/antialiased_line_rasterizer_top.sv -----
`default_nettype none
// A pixel write forms the row address, then writes; a pixel read forms it,
// reads the store, then returns the word. A line runs square-root and two
// divide iterations on one shared subtractor, then per step up to three
// read-modify-write accesses on the single frame store port. One command at
// a time; the result strobe rises in the cycle after the last work cycle.
// After reset a clearing pass writes all 65536 pixels, one per cycle, busy high.
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_top
// Command-driven line, pixel write and pixel read engine over an RGB store.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [aalr_pkg::CMD_W-1:0]        command_i,
  input  logic signed [aalr_pkg::CRD_W-1:0] x_start_i,
  input  logic signed [aalr_pkg::CRD_W-1:0] y_start_i,
  input  logic signed [aalr_pkg::CRD_W-1:0] x_end_i,
  input  logic signed [aalr_pkg::CRD_W-1:0] y_end_i,
  input  logic [aalr_pkg::PIX_W-1:0]        colour_i,
  input  logic                              cfg_we_i,
  input  logic [aalr_pkg::CIDX_W-1:0]       cfg_idx_i,
  input  logic [aalr_pkg::DIM_W-1:0]        cfg_data_i,
  output logic                              result_valid_o,
  output logic [aalr_pkg::RES_W-1:0]        read_colour_o,
  output logic                              clipped_o
);
  import aalr_pkg::*;

  function automatic logic signed [IW-1:0] trunc_int(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [IW-1:0] im;
    mag = p[PW-1] ? $unsigned(-p) : $unsigned(p);
    im  = IW'(mag >> FRAC_BITS);
    return p[PW-1] ? -$signed(im) : $signed(im);
  endfunction

  function automatic logic on_scr(input logic signed [IW-1:0] x,
                                  input logic signed [IW-1:0] y,
                                  input logic [DIM_W-1:0] w,
                                  input logic [DIM_W-1:0] h);
    return (x >= 0) && (x < $signed(IW'(w))) && (y >= 0) && (y < $signed(IW'(h)));
  endfunction

  function automatic logic [WW-1:0] sat_weight(input logic signed [PRW-1:0] p);
    logic signed [PRW-1:0] s;
    s = p >>> FRAC_BITS;
    if (p < 0) return '0;
    if (s > $signed(PRW'(ONE_W))) return ONE_W;
    return WW'(s);
  endfunction

  function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] c,
                                             input logic [PIX_W-1:0] o,
                                             input logic [WW-1:0] w);
    logic [PIX_W-1:0] r;
    logic [WW+9:0]    acc;
    logic [WW+9:0]    v;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      acc = (WW+10)'(c[8*k +: 8]) * (WW+10)'(w)
          + (WW+10)'(o[8*k +: 8]) * (WW+10)'(ONE_W - w)
          + (WW+10)'(ONE_W >> 1);
      v = acc >> FRAC_BITS;
      r[8*k +: 8] = (v > (WW+10)'(255)) ? 8'hFF : v[7:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;
  logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;
  logic [AW-1:0]    clr_q, clr_d;
  logic             res_valid_q, res_valid_d;
  logic [RES_W-1:0] res_colour_q, res_colour_d;
  logic             res_clip_q, res_clip_d;

  logic signed [CRD_W-1:0] x1_q, x1_d, y1_q, y1_d;
  logic signed [DW-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic [PIX_W-1:0]        colour_q, colour_d;
  logic [XW-1:0]           pix_x_q, pix_x_d;
  logic [YW-1:0]           pix_y_q, pix_y_d;
  logic                    onscr1_q, onscr1_d;
  logic [SW-1:0]           sq_q, sq_d;
  logic [UW-1:0]           v_q, v_d, res_q, res_d, bit_q, bit_d, rem_q, rem_d;
  logic [LW-1:0]           lenq_q, lenq_d;
  logic [NUMW-1:0]         num_q, num_d;
  logic [QW-1:0]           quo_q, quo_d;
  logic signed [QW-1:0]    dirx_q, dirx_d, diry_q, diry_d;
  logic signed [PW-1:0]    px_q, px_d, py_q, py_d;
  logic signed [IW-1:0]    ix_q, ix_d, iy_q, iy_d;
  logic signed [FW-1:0]    fx_q, fx_d, fy_q, fy_d;
  logic [1:0]              nb_q, nb_d;
  logic signed [PRW-1:0]   prod_q, prod_d;
  logic [AW-1:0]           row_q, row_d;
  logic [WW-1:0]           w_q, w_d;
  logic [CW-1:0]           cnt_q, cnt_d;

  fs_req_t          fs_req;
  logic [PIX_W-1:0] fs_rdata;

  // shared subtract/compare unit
  logic [UW-1:0] ua, ub;
  logic [UW:0]   udiff;
  logic          uge;

  logic signed [SW-1:0] sq_op_prod;
  logic signed [DW-1:0] sq_op;

  aalr_fstore u_fstore (
    .clk_i   (clk_i),
    .req_i   (fs_req),
    .rdata_o (fs_rdata)
  );

  always_comb begin
    if (width_q == '0) w_eff = DIM_W'(1);
    else if (int'(width_q) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = width_q;
    if (height_q == '0) h_eff = DIM_W'(1);
    else if (int'(height_q) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = height_q;
  end

  always_comb begin
    ua = '0;
    ub = '0;
    case (state_q)
      ST_ISQ: begin
        ua = v_q;
        ub = res_q + bit_q;
      end
      ST_DIVX, ST_DIVY: begin
        ua = {rem_q[UW-2:0], num_q[NUMW-1]};
        ub = UW'(lenq_q);
      end
      default: ;
    endcase
  end

  assign udiff = {1'b0, ua} - {1'b0, ub};
  assign uge   = !udiff[UW];

  assign sq_op      = (state_q == ST_SQX) ? dx_q : dy_q;
  assign sq_op_prod = sq_op * sq_op;

  always_comb begin
    logic signed [IW-1:0]  xs, ys, xe, ye, ws, hs, nx, ny;
    logic signed [AFW-1:0] fa, fb;
    logic signed [PW-1:0]  ixe, iye;
    logic signed [DW-1:0]  absd;
    logic [SW-1:0]         ssum;
    logic [UW-1:0]         nres, nrem;
    logic [QW-1:0]         nquo;
    logic signed [QW-1:0]  ndir;
    logic                  nvalid, dneg;
    logic [AW-1:0]         pix_addr;

    state_d      = state_q;
    clr_d        = clr_q;
    res_valid_d  = 1'b0;
    res_colour_d = res_colour_q;
    res_clip_d   = res_clip_q;
    x1_d = x1_q;  y1_d = y1_q;  dx_d = dx_q;  dy_d = dy_q;
    colour_d = colour_q;  pix_x_d = pix_x_q;  pix_y_d = pix_y_q;
    onscr1_d = onscr1_q;  sq_d = sq_q;
    v_d = v_q;  res_d = res_q;  bit_d = bit_q;  rem_d = rem_q;
    lenq_d = lenq_q;  num_d = num_q;  quo_d = quo_q;
    dirx_d = dirx_q;  diry_d = diry_q;  px_d = px_q;  py_d = py_q;
    ix_d = ix_q;  iy_d = iy_q;  fx_d = fx_q;  fy_d = fy_q;
    nb_d = nb_q;  prod_d = prod_q;  row_d = row_q;  w_d = w_q;  cnt_d = cnt_q;
    fs_req = '0;

    xs = IW'(x_start_i);  ys = IW'(y_start_i);
    xe = IW'(x_end_i);    ye = IW'(y_end_i);
    ws = $signed(IW'(w_eff));
    hs = $signed(IW'(h_eff));
    nx = ix_q;  ny = iy_q;  fa = '0;  fb = '0;  nvalid = 1'b0;
    ixe = PW'(ix_q);  iye = PW'(iy_q);
    ssum = sq_q + $unsigned(sq_op_prod);
    nres = uge ? (res_q >> 1) + bit_q : res_q >> 1;
    nrem = uge ? udiff[UW-1:0] : ua;
    nquo = {quo_q[QW-2:0], uge};
    dneg = (state_q == ST_DIVX) ? dx_q[DW-1] : dy_q[DW-1];
    ndir = dneg ? -$signed(nquo) : $signed(nquo);
    absd = dy_q[DW-1] ? -dy_q : dy_q;
    pix_addr = row_q + AW'(pix_x_q);

    case (state_q)
      ST_CLR: begin
        fs_req.we   = 1'b1;
        fs_req.addr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          colour_d = colour_i;
          x1_d = x_start_i;  y1_d = y_start_i;
          pix_x_d = x_start_i[XW-1:0];
          pix_y_d = y_start_i[YW-1:0];
          dx_d = DW'(x_end_i) - DW'(x_start_i);
          dy_d = DW'(y_end_i) - DW'(y_start_i);
          onscr1_d = on_scr(xs, ys, w_eff, h_eff);
          case (cmd_e'(command_i))
            CMD_LINE: begin
              if ((xs < 0 && xe < 0) || (ys < 0 && ye < 0) ||
                  (xs >= ws && xe >= ws) || (ys >= hs && ye >= hs)) begin
                res_valid_d = 1'b1;  res_colour_d = '0;  res_clip_d = 1'b1;
              end else begin
                state_d = ST_SQX;
              end
            end
            CMD_WRITE, CMD_READ: begin
              if (on_scr(xs, ys, w_eff, h_eff)) begin
                state_d = (cmd_e'(command_i) == CMD_WRITE) ? ST_WMUL : ST_RMUL;
              end else begin
                res_valid_d = 1'b1;  res_colour_d = '0;  res_clip_d = 1'b1;
              end
            end
            default: begin
              res_valid_d = 1'b1;  res_colour_d = '0;  res_clip_d = 1'b0;
            end
          endcase
        end
      end
      ST_SQX: begin
        sq_d    = $unsigned(sq_op_prod);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        if (ssum == '0) begin
          if (onscr1_q) begin
            state_d = ST_WMUL;
          end else begin
            res_valid_d = 1'b1;  res_colour_d = '0;  res_clip_d = 1'b0;
            state_d = ST_IDLE;
          end
        end else begin
          v_d   = UW'(ssum) << (2 * FRAC_BITS);
          res_d = '0;
          bit_d = UW'(1) << (VW - 2);
          cnt_d = CW'(ISQ_ITERS);
          state_d = ST_ISQ;
        end
      end
      ST_ISQ: begin
        if (uge) v_d = udiff[UW-1:0];
        res_d = nres;
        bit_d = bit_q >> 2;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          lenq_d = nres[LW-1:0];
          num_d  = NUMW'($unsigned(dx_q[DW-1] ? -dx_q : dx_q)) << (2 * FRAC_BITS);
          rem_d  = '0;
          quo_d  = '0;
          cnt_d  = CW'(NUMW);
          state_d = ST_DIVX;
        end
      end
      ST_DIVX, ST_DIVY: begin
        rem_d = nrem;
        quo_d = nquo;
        num_d = num_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          if (state_q == ST_DIVX) begin
            dirx_d = ndir;
            num_d  = NUMW'($unsigned(absd)) << (2 * FRAC_BITS);
            rem_d  = '0;
            quo_d  = '0;
            cnt_d  = CW'(NUMW);
            state_d = ST_DIVY;
          end else begin
            diry_d = ndir;
            px_d   = $signed(PW'(x1_q)) <<< FRAC_BITS;
            py_d   = $signed(PW'(y1_q)) <<< FRAC_BITS;
            cnt_d  = CW'(lenq_q[LW-1:FRAC_BITS]) + CW'(1);
            state_d = ST_POS;
          end
        end
      end
      ST_POS: begin
        ix_d = trunc_int(px_q);
        iy_d = trunc_int(py_q);
        ixe  = PW'(ix_d);
        iye  = PW'(iy_d);
        fx_d = FW'(px_q - (ixe <<< FRAC_BITS));
        fy_d = FW'(py_q - (iye <<< FRAC_BITS));
        nb_d = 2'd0;
        state_d = ST_NB;
      end
      ST_NB: begin
        case (nb_q)
          2'd0: begin
            nvalid = on_scr(ix_q, iy_q, w_eff, h_eff);
            fa = ONE_F - AFW'(fx_q);  fb = ONE_F - AFW'(fy_q);
          end
          2'd1: begin
            nx = ix_q + IW'(1);
            nvalid = nx < ws;
            fa = AFW'(fx_q);  fb = ONE_F - AFW'(fy_q);
          end
          2'd2: begin
            ny = iy_q + IW'(1);
            nvalid = ny < hs;
            fa = ONE_F - AFW'(fx_q);  fb = AFW'(fy_q);
          end
          default: nvalid = 1'b0;
        endcase
        if (nvalid) begin
          pix_x_d = nx[XW-1:0];
          pix_y_d = ny[YW-1:0];
          prod_d  = fa * fb;
          row_d   = AW'(ny[YW-1:0] * w_eff);
          state_d = ST_PRD;
        end else if (nb_q == 2'd0 || nb_q == 2'd2) begin
          // off-screen base pixel drops the whole step; off-screen lower one ends it
          state_d = ST_NEXT;
        end else begin
          nb_d = nb_q + 2'd1;
        end
      end
      ST_PRD: begin
        fs_req.re   = 1'b1;
        fs_req.addr = pix_addr;
        w_d = sat_weight(prod_q);
        state_d = ST_PBL;
      end
      ST_PBL: begin
        fs_req.we    = 1'b1;
        fs_req.addr  = pix_addr;
        fs_req.wdata = blend(colour_q, fs_rdata, w_q);
        if (nb_q == 2'd2) begin
          state_d = ST_NEXT;
        end else begin
          nb_d = nb_q + 2'd1;
          state_d = ST_NB;
        end
      end
      ST_NEXT: begin
        px_d = px_q + PW'(dirx_q);
        py_d = py_q + PW'(diry_q);
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          res_valid_d = 1'b1;  res_colour_d = '0;  res_clip_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_POS;
        end
      end
      ST_WMUL: begin
        row_d   = AW'(pix_y_q * w_eff);
        state_d = ST_WWR;
      end
      ST_WWR: begin
        fs_req.we    = 1'b1;
        fs_req.addr  = pix_addr;
        fs_req.wdata = colour_q;
        res_valid_d = 1'b1;  res_colour_d = '0;  res_clip_d = 1'b0;
        state_d = ST_IDLE;
      end
      ST_RMUL: begin
        row_d   = AW'(pix_y_q * w_eff);
        state_d = ST_RRD;
      end
      ST_RRD: begin
        fs_req.re   = 1'b1;
        fs_req.addr = pix_addr;
        state_d = ST_ROUT;
      end
      ST_ROUT: begin
        res_valid_d  = 1'b1;
        res_colour_d = {ALPHA, fs_rdata};
        res_clip_d   = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      width_q     <= DIM_W'(MAX_WIDTH);
      height_q    <= DIM_W'(MAX_HEIGHT);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_WIDTH) width_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_HEIGHT) height_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_colour_q <= res_colour_d;
    res_clip_q   <= res_clip_d;
    x1_q <= x1_d;  y1_q <= y1_d;  dx_q <= dx_d;  dy_q <= dy_d;
    colour_q <= colour_d;  pix_x_q <= pix_x_d;  pix_y_q <= pix_y_d;
    onscr1_q <= onscr1_d;  sq_q <= sq_d;
    v_q <= v_d;  res_q <= res_d;  bit_q <= bit_d;  rem_q <= rem_d;
    lenq_q <= lenq_d;  num_q <= num_d;  quo_q <= quo_d;
    dirx_q <= dirx_d;  diry_q <= diry_d;  px_q <= px_d;  py_q <= py_d;
    ix_q <= ix_d;  iy_q <= iy_d;  fx_q <= fx_d;  fy_q <= fy_d;
    nb_q <= nb_d;  prod_q <= prod_d;  row_q <= row_d;  w_q <= w_d;  cnt_q <= cnt_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign read_colour_o  = res_colour_q;
  assign clipped_o      = res_clip_q;

`ifndef SYNTHESIS
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result word while busy");
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && clipped_o) |-> (read_colour_o == '0))
    else $error("clipped word carries colour");
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && read_colour_o != '0) |-> (read_colour_o[31:24] == ALPHA))
    else $error("read word without alpha");
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !result_valid_o || clipped_o || $past(command_i) != CMD_READ)
    else $error("read answered without memory access");
`endif

endmodule
`default_nettype wire
